### hw/rtl/fcrf_pkg.sv
package fcrf_pkg;

	localparam int QUEUE_SLOTS_DEF     = 8;
	localparam int MAX_FRAME_BYTES_DEF = 64;

	// Field widths sized for the largest supported slot count and frame size.
	localparam int SLOT_W_MAX = 7;
	localparam int BIDX_W_MAX = 6;
	localparam int LEN_W      = 7;

	localparam int CMDQ_DEPTH = 4;

	typedef enum logic [1:0] {
		MODE_PUSH    = 2'd0,
		MODE_PEEK    = 2'd1,
		MODE_CONSUME = 2'd2,
		MODE_FLUSH   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_EMPTY_FRAME = 3'd1,
		ST_TOO_LARGE   = 3'd2,
		ST_RING_FULL   = 3'd3,
		ST_RING_EMPTY  = 3'd4
	} status_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        frame_end;
		logic [31:0] frame_tag;
	} in_word_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       out_byte;
		logic [31:0]      out_tag;
		logic [LEN_W-1:0] out_length;
		logic             last_item;
		logic [2:0]       dropped_count;
		logic [2:0]       queue_depth;
	} out_word_t;

	typedef enum logic {
		CMD_RESULT = 1'b0,
		CMD_PEEK   = 1'b1
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t               op;
		logic                  wr_en;
		logic                  commit_en;
		logic [SLOT_W_MAX-1:0] slot;
		logic [BIDX_W_MAX-1:0] idx;
		logic [7:0]            wr_data;
		logic [LEN_W-1:0]      commit_len;
		logic [31:0]           commit_tag;
		status_t               status;
		logic [2:0]            dropped;
		logic [2:0]            depth;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE   = 2'd0,
		BK_META   = 2'd1,
		BK_STREAM = 2'd2
	} back_state_t;

endpackage

### hw/rtl/fcrf_front.sv
module fcrf_front import fcrf_pkg::*; #(
	parameter int QUEUE_SLOTS     = QUEUE_SLOTS_DEF,
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  in_word_t req,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);

	localparam int IW = $clog2(QUEUE_SLOTS);
	localparam int BW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

	logic [IW-1:0] w_q, r_q, w_n, r_n, w_next, r_next;
	logic [CW-1:0] cnt_q, cnt_n, cnt1;
	logic          ovf_q, ovf_n, ovf1;
	logic          accept;

	function automatic logic [2:0] queue_depth3(input logic [IW-1:0] w, input logic [IW-1:0] r);
		logic [IW:0]   d;
		logic [IW+2:0] e;
		d = {1'b0, w} + (IW+1)'(QUEUE_SLOTS) - {1'b0, r};
		if (d >= (IW+1)'(QUEUE_SLOTS)) begin
			d = d - (IW+1)'(QUEUE_SLOTS);
		end
		e = (IW+3)'(d);
		return e[2:0];
	endfunction

	assign req_ready = cmd_ready;
	assign cmd_valid = req_valid;
	assign accept    = req_valid && cmd_ready;

	assign w_next = (w_q == IW'(QUEUE_SLOTS - 1)) ? '0 : w_q + 1'b1;
	assign r_next = (r_q == IW'(QUEUE_SLOTS - 1)) ? '0 : r_q + 1'b1;

	always_comb begin
		w_n   = w_q;
		r_n   = r_q;
		cnt1  = cnt_q;
		ovf1  = ovf_q;
		cnt_n = cnt_q;
		ovf_n = ovf_q;
		cmd            = '0;
		cmd.op         = CMD_RESULT;
		cmd.status     = ST_OK;
		cmd.slot       = SLOT_W_MAX'(w_q);
		cmd.idx        = BIDX_W_MAX'(cnt_q[BW-1:0]);
		cmd.wr_data    = req.data_byte;
		cmd.commit_tag = req.frame_tag;
		unique case (req.mode)
			MODE_PUSH: begin
				if (req.has_byte) begin
					if (cnt_q < CW'(MAX_FRAME_BYTES)) begin
						cmd.wr_en = 1'b1;
						cnt1      = cnt_q + 1'b1;
					end else begin
						ovf1 = 1'b1;
					end
				end
				cnt_n = cnt1;
				ovf_n = ovf1;
				if (req.frame_end) begin
					if (cnt1 == '0 && !ovf1) begin
						cmd.status = ST_EMPTY_FRAME;
					end else if (ovf1) begin
						cmd.status = ST_TOO_LARGE;
					end else if (w_next == r_q) begin
						cmd.status = ST_RING_FULL;
					end else begin
						cmd.commit_en  = 1'b1;
						cmd.commit_len = LEN_W'(cnt1);
						w_n            = w_next;
					end
					cnt_n = '0;
					ovf_n = 1'b0;
				end
			end
			MODE_PEEK: begin
				if (r_q == w_q) begin
					cmd.status = ST_RING_EMPTY;
				end else begin
					cmd.op   = CMD_PEEK;
					cmd.slot = SLOT_W_MAX'(r_q);
				end
			end
			MODE_CONSUME: begin
				if (r_q == w_q) begin
					cmd.status = ST_RING_EMPTY;
				end else begin
					r_n = r_next;
				end
			end
			MODE_FLUSH: begin
				cmd.dropped = queue_depth3(w_q, r_q);
				r_n         = w_q;
			end
			default: begin
			end
		endcase
		cmd.depth = queue_depth3(w_n, r_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= '0;
			r_q   <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			w_q   <= w_n;
			r_q   <= r_n;
			cnt_q <= cnt_n;
			ovf_q <= ovf_n;
		end
	end

endmodule

### hw/rtl/fcrf_cmd_queue.sv
module fcrf_cmd_queue import fcrf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

	cmd_t          entries_q [CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push, pop;

	assign push_ready = (count_q != (PW+1)'(CMDQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

### hw/rtl/fcrf_back.sv
module fcrf_back import fcrf_pkg::*; #(
	parameter int QUEUE_SLOTS     = QUEUE_SLOTS_DEF,
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_word_t rsp
);

	localparam int IW    = $clog2(QUEUE_SLOTS);
	localparam int BW    = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
	localparam int CW    = $clog2(MAX_FRAME_BYTES + 1);
	localparam int DEPTH = QUEUE_SLOTS << BW;

	// Frame storage, one row of 2**BW bytes per slot.
	logic [7:0]    byte_mem [DEPTH];
	logic [CW-1:0] len_mem  [QUEUE_SLOTS];
	logic [31:0]   tag_mem  [QUEUE_SLOTS];

	back_state_t   state_q, state_n;
	logic [IW-1:0] slot_q, cmd_slot;
	logic [BW-1:0] idx_q, cmd_idx;
	logic [2:0]    depth_q;
	logic [CW-1:0] len_rd_q;
	logic [31:0]   tag_rd_q;
	logic [7:0]    byte_rd_q;

	logic      byte_we, meta_we, byte_re, meta_re, peek_start, stream_issue;
	logic      iss_valid, iss_mem, last_c;
	out_word_t iss_word;

	logic      s1_valid_q, s1_mem_s1;
	out_word_t s1_word_s1, s1_out;

	out_word_t  ofifo_q [2];
	logic       ofifo_wr_q, ofifo_rd_q;
	logic [1:0] ofifo_cnt_q;
	logic       rsp_pop, room;
	logic [2:0] occ_next;

	assign cmd_slot = cmd.slot[IW-1:0];
	assign cmd_idx  = cmd.idx[BW-1:0];

	assign rsp_valid = (ofifo_cnt_q != 2'd0);
	assign rsp       = ofifo_q[ofifo_rd_q];
	assign rsp_pop   = rsp_valid && rsp_ready;

	// An issued word passes through the s1 register before it is written into the output
	// buffer, so issue only when the buffer is sure to have a free entry by then.
	assign occ_next = 3'(ofifo_cnt_q) + 3'(s1_valid_q) - 3'(rsp_pop);
	assign room     = (occ_next <= 3'd1);

	assign last_c = (len_rd_q == '0) || ((CW'(idx_q) + 1'b1) == len_rd_q);

	always_comb begin
		state_n      = state_q;
		cmd_ready    = 1'b0;
		byte_we      = 1'b0;
		meta_we      = 1'b0;
		byte_re      = 1'b0;
		meta_re      = 1'b0;
		peek_start   = 1'b0;
		stream_issue = 1'b0;
		iss_valid    = 1'b0;
		iss_mem      = 1'b0;
		iss_word     = '0;
		iss_word.status = ST_OK;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == CMD_PEEK) begin
						cmd_ready  = 1'b1;
						meta_re    = 1'b1;
						peek_start = 1'b1;
						state_n    = BK_META;
					end else if (room) begin
						cmd_ready              = 1'b1;
						byte_we                = cmd.wr_en;
						meta_we                = cmd.commit_en;
						iss_valid              = 1'b1;
						iss_word.status        = cmd.status;
						iss_word.last_item     = 1'b1;
						iss_word.dropped_count = cmd.dropped;
						iss_word.queue_depth   = cmd.depth;
					end
				end
			end
			BK_META: begin
				state_n = BK_STREAM;
			end
			BK_STREAM: begin
				if (room) begin
					stream_issue          = 1'b1;
					iss_valid             = 1'b1;
					iss_mem               = (len_rd_q != '0);
					byte_re               = (len_rd_q != '0);
					iss_word.out_tag      = tag_rd_q;
					iss_word.out_length   = LEN_W'(len_rd_q);
					iss_word.last_item    = last_c;
					iss_word.queue_depth  = depth_q;
					if (last_c) begin
						state_n = BK_IDLE;
					end
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[{cmd_slot, cmd_idx}] <= cmd.wr_data;
		end
		if (byte_re) begin
			byte_rd_q <= byte_mem[{slot_q, idx_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			len_mem[cmd_slot] <= cmd.commit_len[CW-1:0];
			tag_mem[cmd_slot] <= cmd.commit_tag;
		end
		if (meta_re) begin
			len_rd_q <= len_mem[cmd_slot];
			tag_rd_q <= tag_mem[cmd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (peek_start) begin
			slot_q  <= cmd_slot;
			depth_q <= cmd.depth;
			idx_q   <= '0;
		end else if (stream_issue) begin
			idx_q <= idx_q + 1'b1;
		end
		s1_word_s1 <= iss_word;
		s1_mem_s1  <= iss_mem;
	end

	always_comb begin
		s1_out = s1_word_s1;
		if (s1_mem_s1) begin
			s1_out.out_byte = byte_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			ofifo_q[ofifo_wr_q] <= s1_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			ofifo_wr_q  <= 1'b0;
			ofifo_rd_q  <= 1'b0;
			ofifo_cnt_q <= 2'd0;
		end else begin
			s1_valid_q <= iss_valid;
			if (s1_valid_q) begin
				ofifo_wr_q <= ~ofifo_wr_q;
			end
			if (rsp_pop) begin
				ofifo_rd_q <= ~ofifo_rd_q;
			end
			ofifo_cnt_q <= ofifo_cnt_q + 2'(s1_valid_q) - 2'(rsp_pop);
		end
	end

endmodule

### hw/rtl/framed_command_ring_fifo.sv
// Path: an accepted word passes through the command queue, the s1 register and the output buffer;
// a peek first reads the frame's length and tag (state BK_META) before its bytes stream out.
// Throughput: one word per cycle for push, consume and flush while the output is not stalled; a peek holds
// the back end while its bytes stream out, and a four-entry command queue keeps input going until it fills.
// Reset (arst_n low): ring indices, gathered byte count, oversize flag, command queue and output buffer
// clear; frame storage is left as it was and is only read after a commit writes it.
module framed_command_ring_fifo import fcrf_pkg::*; #(
	parameter int QUEUE_SLOTS     = QUEUE_SLOTS_DEF,
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_word_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_word_t rsp
);

	logic front_valid, front_ready, back_valid, back_ready;
	cmd_t front_cmd, back_cmd;

	fcrf_front #(
		.QUEUE_SLOTS    (QUEUE_SLOTS),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready),
		.cmd      (front_cmd)
	);

	fcrf_cmd_queue u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_cmd  (front_cmd),
		.pop_valid (back_valid),
		.pop_ready (back_ready),
		.pop_cmd   (back_cmd)
	);

	fcrf_back #(
		.QUEUE_SLOTS    (QUEUE_SLOTS),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(back_valid),
		.cmd_ready(back_ready),
		.cmd      (back_cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

### sim/tb_framed_command_ring_fifo.sv
`timescale 1ns / 1ps

module tb_framed_command_ring_fifo;
	import fcrf_pkg::*;

	localparam int SLOTS          = QUEUE_SLOTS_DEF;
	localparam int FRAME_MAX      = MAX_FRAME_BYTES_DEF;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_WORDS   = 30;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	in_word_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	out_word_t rsp;

	// Shadow copy of the ring, updated as each request word is issued.
	logic [7:0]       frame_mem [SLOTS][FRAME_MAX];
	logic [LEN_W-1:0] frame_len [SLOTS];
	logic [31:0]      frame_tag [SLOTS];
	int               wr_slot;
	int               rd_slot;
	int               gather_cnt;
	bit               gather_over;

	out_word_t ring_rsp_q[$];
	int        mismatch_cnt;
	int        words_sent;
	int        quiet_cycles;
	bit        sender_idle_on;
	bit        recv_idle_on;
	bit        hold_req;
	int        hold_cnt;
	int        stall_cnt;

	framed_command_ring_fifo u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic int ring_depth();
		return (wr_slot + SLOTS - rd_slot) % SLOTS;
	endfunction

	function automatic in_word_t make_word(mode_t m, logic [7:0] d, logic hb, logic fe,
			logic [31:0] tag);
		in_word_t w;
		w.mode      = m;
		w.data_byte = d;
		w.has_byte  = hb;
		w.frame_end = fe;
		w.frame_tag = tag;
		return w;
	endfunction

	// Works out every response word that one request word produces.
	function automatic void compute_ring_response(in_word_t w);
		out_word_t r;
		int        nxt;
		int        len;
		r           = '0;
		r.status    = ST_OK;
		r.last_item = 1'b1;
		case (w.mode)
			MODE_PUSH: begin
				if (w.has_byte) begin
					if (gather_cnt < FRAME_MAX) begin
						frame_mem[wr_slot][gather_cnt] = w.data_byte;
						gather_cnt++;
					end else begin
						gather_over = 1'b1;
					end
				end
				if (w.frame_end) begin
					nxt = (wr_slot + 1) % SLOTS;
					if (gather_cnt == 0 && !gather_over) begin
						r.status = ST_EMPTY_FRAME;
					end else if (gather_over) begin
						r.status = ST_TOO_LARGE;
					end else if (nxt == rd_slot) begin
						r.status = ST_RING_FULL;
					end else begin
						frame_len[wr_slot] = LEN_W'(gather_cnt);
						frame_tag[wr_slot] = w.frame_tag;
						wr_slot = nxt;
					end
					gather_cnt  = 0;
					gather_over = 1'b0;
				end
				r.queue_depth = 3'(ring_depth());
				ring_rsp_q.push_back(r);
			end
			MODE_PEEK: begin
				if (rd_slot == wr_slot) begin
					r.status      = ST_RING_EMPTY;
					r.queue_depth = 3'(ring_depth());
					ring_rsp_q.push_back(r);
				end else begin
					len = frame_len[rd_slot];
					for (int i = 0; i < len; i++) begin
						r.out_byte    = frame_mem[rd_slot][i];
						r.out_tag     = frame_tag[rd_slot];
						r.out_length  = LEN_W'(len);
						r.last_item   = (i == len - 1);
						r.queue_depth = 3'(ring_depth());
						ring_rsp_q.push_back(r);
					end
				end
			end
			MODE_CONSUME: begin
				if (rd_slot == wr_slot) begin
					r.status = ST_RING_EMPTY;
				end else begin
					rd_slot = (rd_slot + 1) % SLOTS;
				end
				r.queue_depth = 3'(ring_depth());
				ring_rsp_q.push_back(r);
			end
			default: begin
				r.dropped_count = 3'(ring_depth());
				rd_slot         = wr_slot;
				r.queue_depth   = 3'(ring_depth());
				ring_rsp_q.push_back(r);
			end
		endcase
	endfunction

	function automatic void check_ring_response(out_word_t got);
		out_word_t want;
		if (ring_rsp_q.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("%0t: response with nothing pending: %h", $time, got);
			return;
		end
		want = ring_rsp_q.pop_front();
		if (got.status !== want.status || got.out_byte !== want.out_byte
				|| got.out_tag !== want.out_tag || got.out_length !== want.out_length
				|| got.last_item !== want.last_item || got.dropped_count !== want.dropped_count
				|| got.queue_depth !== want.queue_depth) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10) begin
				$display("%0t: mismatch exp st=%0d byte=%h tag=%h len=%0d last=%b drop=%0d dep=%0d",
					$time, want.status, want.out_byte, want.out_tag, want.out_length,
					want.last_item, want.dropped_count, want.queue_depth);
				$display("    got st=%0d byte=%h tag=%h len=%0d last=%b drop=%0d dep=%0d",
					got.status, got.out_byte, got.out_tag, got.out_length,
					got.last_item, got.dropped_count, got.queue_depth);
			end
		end
	endfunction

	// Receiver: checks each accepted word, then picks next cycle's ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_ring_response(rsp);
			if (hold_req && hold_cnt == 0) begin
				hold_cnt = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_ready <= 1'b0;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				rsp_ready <= 1'b0;
			end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
				stall_cnt = $urandom_range(0, 9);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Entered right after a rising edge; returns right after the accepting edge.
	task automatic send_word(in_word_t w);
		if (sender_idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		compute_ring_response(w);
		req       <= w;
		req_valid <= 1'b1;
		words_sent++;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic send_op(mode_t m);
		send_word(make_word(m, 8'($urandom), 1'($urandom), 1'($urandom), $urandom));
	endtask

	// A frame of n bytes; the last byte may ride on the end word.
	task automatic send_frame(int n, bit byte_on_end, logic [31:0] tag);
		if (n == 0) begin
			send_word(make_word(MODE_PUSH, 8'($urandom), 1'b0, 1'b1, tag));
		end else begin
			for (int i = 0; i < n - 1; i++)
				send_word(make_word(MODE_PUSH, 8'($urandom), 1'b1, 1'b0, $urandom));
			if (byte_on_end) begin
				send_word(make_word(MODE_PUSH, 8'($urandom), 1'b1, 1'b1, tag));
			end else begin
				send_word(make_word(MODE_PUSH, 8'($urandom), 1'b1, 1'b0, $urandom));
				send_word(make_word(MODE_PUSH, 8'($urandom), 1'b0, 1'b1, tag));
			end
		end
	endtask

	task automatic wait_ring_drained();
		req_valid <= 1'b0;
		while (ring_rsp_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_ring();
		send_op(MODE_PEEK);
		send_op(MODE_CONSUME);
		send_op(MODE_FLUSH);
		send_word(make_word(MODE_PUSH, 8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFF));
		send_word(make_word(MODE_PUSH, 8'h00, 1'b0, 1'b1, 32'h0));
	endtask

	task automatic test_ring_full();
		for (int k = 0; k < SLOTS - 1; k++)
			send_frame(1 + k % 3, k[0], (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom);
		send_frame(2, 1'b1, $urandom);
		send_op(MODE_PEEK);
		send_op(MODE_CONSUME);
		send_op(MODE_PEEK);
		// A frame half gathered survives peek and flush and commits afterwards.
		send_word(make_word(MODE_PUSH, 8'h00, 1'b1, 1'b0, 32'h0));
		send_word(make_word(MODE_PUSH, 8'hFF, 1'b1, 1'b0, 32'h0));
		send_op(MODE_PEEK);
		send_op(MODE_FLUSH);
		send_word(make_word(MODE_PUSH, 8'h5A, 1'b0, 1'b1, 32'hA5A5_0F0F));
		send_op(MODE_PEEK);
		send_op(MODE_CONSUME);
	endtask

	task automatic test_frame_limits();
		send_frame(FRAME_MAX, 1'b1, $urandom);
		send_op(MODE_PEEK);
		send_frame(FRAME_MAX + 1, 1'b0, $urandom);
		send_op(MODE_CONSUME);
		send_op(MODE_PEEK);
		send_op(MODE_FLUSH);
	endtask

	task automatic test_backpressure();
		send_frame(8, 1'b0, $urandom);
		hold_req = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (i % 4 == 3)
				send_word(make_word(MODE_PUSH, 8'($urandom), 1'b0, 1'b0, $urandom));
			else
				send_op(MODE_PEEK);
		end
		wait_ring_drained();
		send_op(MODE_FLUSH);
	endtask

	task automatic test_random_traffic();
		int start;
		int pick;
		int len;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			// The tail of the run goes without any idling on either side.
			if (words_sent - start >= RANDOM_WORDS - 15) begin
				sender_idle_on = 1'b0;
				recv_idle_on   = 1'b0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = $urandom_range(0, 19);
				if (len == 0)
					len = 0;
				else if (len <= 2)
					len = $urandom_range(FRAME_MAX - 4, FRAME_MAX + 2);
				else
					len = $urandom_range(1, 6);
				send_frame(len, 1'($urandom), $urandom);
			end else if (pick < 72) begin
				send_op(MODE_PEEK);
			end else if (pick < 84) begin
				send_op(MODE_CONSUME);
			end else if (pick < 89) begin
				send_op(MODE_FLUSH);
			end else begin
				send_op(mode_t'($urandom_range(0, 3)));
			end
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		rsp_ready      = 1'b0;
		wr_slot        = 0;
		rd_slot        = 0;
		gather_cnt     = 0;
		gather_over    = 1'b0;
		mismatch_cnt   = 0;
		words_sent     = 0;
		quiet_cycles   = 0;
		sender_idle_on = 1'b1;
		recv_idle_on   = 1'b1;
		hold_req       = 1'b0;
		hold_cnt       = 0;
		stall_cnt      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ring();
		test_ring_full();
		test_frame_limits();
		test_backpressure();
		test_random_traffic();

		wait_ring_drained();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
